// ----- rtl/md5_pkg.sv -----
// Package for the MD5 hash engine: constants, round tables and state types.
// Used by md5_round and md5_hash_engine_core; depends on nothing.
package md5_pkg;

  localparam int WORD_W    = 32;
  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = 4;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by round r.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] i;
    logic [3:0] rl;
    rl = r[3:0];
    unique case (r[5:4])
      2'd0:    i = rl;
      2'd1:    i = 4'((rl << 2) + rl + 4'd1);
      2'd2:    i = 4'((rl << 1) + rl + 4'd5);
      default: i = 4'((rl << 3) - rl);
    endcase
    return i;
  endfunction

endpackage

// ----- rtl/md5_hash_engine_core.sv -----
// MD5 hash engine top level: word intake, padding sequencer and round loop.
// Depends on md5_pkg, md5_ram and md5_round.
//
// Message words are taken one per transfer. Every sixteenth word starts a
// compression of 64 rounds, one per cycle, followed by a fold step that
// adds the result into the chaining value. The block buffer is a single
// RAM whose registered read port feeds the round unit, the read for round
// r+1 being issued during round r. On the last word the sequencer writes
// the pad word (if the last word was full), the zero words and the two
// length words itself, one per cycle, which may take one extra block. The
// ST_OUT step then moves the digest into the output register and
// reinitialises the engine, so the next message can be taken while the
// digest waits for its transfer. If a digest is still waiting when the
// next one is ready, the engine holds until the output register is free.
// No item is accepted while a block is compressed or padded.
module md5_hash_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);
  import md5_pkg::*;

  localparam logic [BUF_AW-1:0] LAST_SLOT    = BUF_AW'(BUF_DEPTH - 1);
  localparam logic [BUF_AW-1:0] PRE_LEN_SLOT = BUF_AW'(BUF_DEPTH - 3);

  state_t state_r, state_nxt;
  abcd_t  cv_r, cv_nxt, wk_r, wk_nxt, rnd_out;
  logic [63:0] bits_r, bits_nxt;
  logic [BUF_AW-1:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic pend_r, pend_nxt;   // the tail of the message still has to be written
  logic pad_r, pad_nxt;     // the 0x80 word is still owed (last word was full)
  logic lenb_r, lenb_nxt;   // the length words are in: this block ends it
  logic out_valid_r, out_valid_nxt;
  logic [63:0] dlo_r, dlo_nxt, dhi_r, dhi_nxt;

  logic              wr_en;
  logic [BUF_AW-1:0] wr_addr, rd_addr;
  logic [31:0]       wr_data, rd_data;
  logic              full;

  logic in_fire, out_fire;
  logic [2:0] nb;
  logic [31:0] keep, lastw;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_digest_low  = dlo_r;
  assign out_digest_high = dhi_r;

  md5_ram #(.WIDTH(WORD_W), .DEPTH(BUF_DEPTH)) u_buf (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  md5_round u_round (.cur(wk_r), .rnd(rnd_r), .msg(rd_data), .nxt(rnd_out));

  always_comb begin
    nb = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    unique case (nb)
      3'd0:    keep = 32'h00000000;
      3'd1:    keep = 32'h000000ff;
      3'd2:    keep = 32'h0000ffff;
      3'd3:    keep = 32'h00ffffff;
      default: keep = 32'hffffffff;
    endcase
    lastw = (in_data_word & keep) | (PAD_BYTE << {nb[1:0], 3'b000});
  end

  // Buffer write and read addressing.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = 32'h0;
    unique case (state_r)
      ST_IDLE: begin
        wr_en   = in_fire;
        wr_data = (in_last_word && nb != 3'd4) ? lastw : in_data_word;
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_data = pad_r ? PAD_BYTE : 32'h0;
      end
      ST_LEN_LO: begin
        wr_en   = 1'b1;
        wr_data = bits_r[31:0];
      end
      ST_LEN_HI: begin
        wr_en   = 1'b1;
        wr_data = bits_r[63:32];
      end
      default: ;
    endcase
    wr_addr = fill_r;
    full    = (fill_r == LAST_SLOT);
    rd_addr = (state_r == ST_ROUND) ? msg_index(rnd_r + 6'd1) : msg_index(6'd0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (full) state_nxt = ST_ROUND;
          else if (in_last_word) begin
            state_nxt = (nb != 3'd4 && fill_r == PRE_LEN_SLOT) ? ST_LEN_LO : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (full) state_nxt = ST_ROUND;
        else if (fill_r == PRE_LEN_SLOT) state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: state_nxt = ST_LEN_HI;
      ST_LEN_HI: state_nxt = ST_ROUND;
      ST_ROUND:  if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (lenb_r) state_nxt = ST_OUT;
        else if (pend_r) state_nxt = ST_PAD;
        else state_nxt = ST_IDLE;
      end
      ST_OUT: if (!out_valid_r || out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and flag updates.
  always_comb begin
    cv_nxt        = cv_r;
    wk_nxt        = wk_r;
    bits_nxt      = bits_r;
    fill_nxt      = wr_en ? BUF_AW'(fill_r + 1'b1) : fill_r;
    rnd_nxt       = rnd_r;
    pend_nxt      = pend_r;
    pad_nxt       = pad_r;
    lenb_nxt      = lenb_r;
    out_valid_nxt = out_valid_r && !out_fire;
    dlo_nxt       = dlo_r;
    dhi_nxt       = dhi_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          bits_nxt = bits_r + (in_last_word ? 64'({nb, 3'b000}) : 64'd32);
          if (in_last_word) begin
            pend_nxt = 1'b1;
            pad_nxt  = (nb == 3'd4);
          end
        end
      end
      ST_PAD:    pad_nxt  = 1'b0;
      ST_LEN_HI: lenb_nxt = 1'b1;
      ST_ROUND: begin
        wk_nxt  = rnd_out;
        rnd_nxt = rnd_r + 6'd1;
      end
      ST_FOLD: begin
        cv_nxt.a = cv_r.a + wk_r.a;
        cv_nxt.b = cv_r.b + wk_r.b;
        cv_nxt.c = cv_r.c + wk_r.c;
        cv_nxt.d = cv_r.d + wk_r.d;
      end
      ST_OUT: begin
        if (!out_valid_r || out_fire) begin
          dlo_nxt       = {cv_r.b, cv_r.a};
          dhi_nxt       = {cv_r.d, cv_r.c};
          out_valid_nxt = 1'b1;
          cv_nxt        = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
          bits_nxt      = 64'd0;
          fill_nxt      = '0;
          pend_nxt      = 1'b0;
          pad_nxt       = 1'b0;
          lenb_nxt      = 1'b0;
        end
      end
      default: ;
    endcase
    // The working copy is loaded from the chaining value as a block starts.
    if (state_r != ST_ROUND && state_nxt == ST_ROUND) begin
      wk_nxt  = cv_r;
      rnd_nxt = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cv_r        <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
      wk_r        <= '0;
      bits_r      <= 64'd0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      pad_r       <= 1'b0;
      lenb_r      <= 1'b0;
      rnd_r       <= 6'd0;
      out_valid_r <= 1'b0;
      dlo_r       <= 64'd0;
      dhi_r       <= 64'd0;
    end else begin
      state_r     <= state_nxt;
      cv_r        <= cv_nxt;
      wk_r        <= wk_nxt;
      bits_r      <= bits_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      pad_r       <= pad_nxt;
      lenb_r      <= lenb_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
      dlo_r       <= dlo_nxt;
      dhi_r       <= dhi_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !in_ready)
    else $error("input accepted during compression");
  a_round_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r != 6'd63) |=> (state_r == ST_ROUND))
    else $error("round loop left early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digest_low) && $stable(out_digest_high)))
    else $error("digest changed while stalled");

endmodule

// ----- rtl/md5_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by md5_hash_engine_core for the block buffer.
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/md5_round.sv -----
// One MD5 round step: mixing function, add chain and rotation.
// Depends on md5_pkg for the round tables and the abcd_t type.
module md5_round (
  input  md5_pkg::abcd_t  cur,
  input  logic [5:0]      rnd,
  input  logic [31:0]     msg,
  output md5_pkg::abcd_t  nxt
);
  import md5_pkg::*;

  logic [31:0] mix;
  logic [31:0] sum;
  logic [4:0]  sh;
  logic [63:0] dbl;

  always_comb begin
    unique case (rnd[5:4])
      2'd0:    mix = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    mix = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    mix = cur.b ^ cur.c ^ cur.d;
      default: mix = cur.c ^ (cur.b | ~cur.d);
    endcase
    sum = cur.a + mix + round_const(rnd) + msg;
    sh  = rot_amount(rnd);
    dbl = {sum, sum} << sh;
    nxt.a = cur.d;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.b + dbl[63:32];
  end

endmodule

// ----- dv/md5_hash_engine_core_test.sv -----
// Self-checking bench for md5_hash_engine_core: streams messages through the
// engine and compares each digest with an MD5 computation held in the bench.
// Depends on the md5_hash_engine_core RTL and, through it, on md5_pkg.
`timescale 1ns / 100ps

module md5_hash_engine_core_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_low;
  logic [63:0] out_digest_high;

  md5_hash_engine_core dut (.*);

  always #6 clk = ~clk;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  // Predicted engine state.
  logic [31:0] chain [4];
  logic [63:0] msg_bits;
  logic [31:0] blk_words [16];
  int          blk_fill;

  logic [127:0] digest_q [$];
  int           errors = 0;
  int           rx_hold = 0;
  int           burst_left = 0;
  bit           no_gaps = 1'b0;

  function automatic void chain_restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    msg_bits = '0;
    blk_fill = 0;
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, hold, sum;
    int idx, g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      g = r / 16;
      case (g)
        0: begin f = (b & c) | (~b & d); idx = r; end
        1: begin f = (b & d) | (c & ~d); idx = 5 * r + 1; end
        2: begin f = b ^ c ^ d; idx = 3 * r + 5; end
        default: begin f = c ^ (b | ~d); idx = 7 * r; end
      endcase
      sum = a + f + K_TAB[r] + blk_words[idx % 16];
      hold = d;
      d = c;
      c = b;
      b = b + ((sum << SHIFT_TAB[g * 4 + r % 4]) | (sum >> (32 - SHIFT_TAB[g * 4 + r % 4])));
      a = hold;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function automatic void push_word(logic [31:0] w);
    blk_words[blk_fill] = w;
    blk_fill++;
    if (blk_fill == 16) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  // Advances the prediction by one accepted word; queues a digest on the last.
  function automatic void md5_absorb(logic [31:0] w, logic [2:0] cnt, logic fin);
    int n;
    logic [31:0] keep;
    if (!fin) begin
      msg_bits += 64'd32;
      push_word(w);
      return;
    end
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    msg_bits += 64'(n * 8);
    if (n == 4) begin
      push_word(w);
      push_word(32'h80);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
      push_word((w & keep) | (32'h80 << (8 * n)));
    end
    while (blk_fill != 14) push_word(32'h0);
    push_word(msg_bits[31:0]);
    push_word(msg_bits[63:32]);
    digest_q.insert(digest_q.size(), {chain[3], chain[2], chain[1], chain[0]});
    chain_restart();
  endfunction

  // Offers one word and returns just after its transfer; idles between bursts unless no_gaps is set.
  task automatic send_word(logic [31:0] w, logic [2:0] cnt, logic fin);
    int gap;
    in_valid <= 1'b1;
    in_data_word <= w;
    in_byte_count <= cnt;
    in_last_word <= fin;
    do @(posedge clk); while (!in_ready);
    md5_absorb(w, cnt, fin);
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    gap = $urandom_range(1, 8);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic send_message(int nwords, logic [2:0] last_cnt, bit all_ones = 0);
    for (int i = 0; i < nwords; i++)
      send_word(all_ones ? 32'hffffffff : $urandom(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(all_ones ? 32'hffffffff : $urandom(), last_cnt, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks each digest transfer and stalls on its own pattern.
  initial begin
    logic [127:0] exp_d;
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest with none expected: got %h %h", $time,
                   out_digest_high, out_digest_low);
          errors++;
        end else begin
          exp_d = digest_q.pop_front();
          if (out_digest_low !== exp_d[63:0]) begin
            $display("%0t: digest_low expected %h got %h", $time, exp_d[63:0],
                     out_digest_low);
            errors++;
          end
          if (out_digest_high !== exp_d[127:64]) begin
            $display("%0t: digest_high expected %h got %h", $time, exp_d[127:64],
                     out_digest_high);
            errors++;
          end
        end
      end
      phase = (phase + 1) % 97;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (phase < 30) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic test_known_messages();
    send_word(32'h0, 3'd0, 1'b1);                // empty message
    send_word(32'hff636261, 3'd3, 1'b1);         // "abc" with junk in the spare byte
    send_word(32'h12345678, 3'd1, 1'b1);
    send_word(32'h12345678, 3'd2, 1'b1);
    send_word(32'hdeadbeef, 3'd4, 1'b1);
    for (int c = 5; c < 8; c++) send_word($urandom(), 3'(c), 1'b1);
    send_message(16, 3'd0);                      // zero count at a block boundary
    send_message(15, 3'd2);                      // last word fills the block
    send_message(13, 3'd3, 1);                   // 55 bytes: length still fits
    send_message(13, 3'd4);                      // 56 bytes: extra block
    send_message(0, 3'd0, 1);
  endtask

  task automatic test_backpressure();
    rx_hold = 400;
    no_gaps = 1'b1;
    for (int m = 0; m < 4; m++) send_message($urandom_range(0, 5), 3'd4);
    no_gaps = 1'b0;
    wait_drained();
    send_message(20, 3'($urandom_range(0, 4)));
  endtask

  task automatic test_random_messages();
    int sent = 0;
    int len;
    while (sent < 1050) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 20);
      no_gaps = ($urandom_range(0, 5) == 0);
      send_message(len, 3'($urandom_range(0, 7)));
      sent += len + 1;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    chain_restart();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_known_messages();
    test_backpressure();
    test_random_messages();
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("md5_hash_engine_core_test OK");
    end else begin
      $display("md5_hash_engine_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("md5_hash_engine_core_test NOT OK");
    $finish;
  end

endmodule
